// ----- src/itoa_pkg.sv -----
// Shared types and constants for the integer to ASCII radix converter.
package itoa_pkg;

  // Operand and digit geometry
  localparam int DATA_W     = 32;
  localparam int RADIX_W    = 5;
  localparam int DIGIT_W    = 4;
  localparam int CHAR_W     = 8;
  localparam int CHUNK_BITS = 8;
  localparam int CHUNKS     = DATA_W / CHUNK_BITS;
  localparam int CHUNK_CNT_W = $clog2(CHUNKS);
  localparam int SHIFT_W    = 3;

  // Radix bounds and the signed base
  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;
  localparam logic [RADIX_W-1:0] RADIX_TEN = 5'd10;

  // Power-of-two bases handled by the shift path
  localparam logic [RADIX_W-1:0] RADIX_TWO     = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_FOUR    = 5'd4;
  localparam logic [RADIX_W-1:0] RADIX_EIGHT   = 5'd8;
  localparam logic [RADIX_W-1:0] RADIX_SIXTEEN = 5'd16;

  // Special characters
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ERROR = 8'h00;

  // Digit glyphs, entry n is the character for digit value n
  localparam logic [15:0][CHAR_W-1:0] GLYPHS = {
    8'h46, 8'h45, 8'h44, 8'h43, 8'h42, 8'h41, 8'h39, 8'h38,
    8'h37, 8'h36, 8'h35, 8'h34, 8'h33, 8'h32, 8'h31, 8'h30
  };

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERROR,
    ST_DIVIDE,
    ST_FETCH,
    ST_SIGN,
    ST_EMIT
  } itoa_state_t;

endpackage

// ----- src/itoa_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module itoa_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- src/integer_to_ascii_radix.sv -----
// Integer to ASCII converter for bases 2 to 16, most significant digit first.
// A request is taken only while the sequencer is idle; each digit then comes from the shift
// path in base 2, 4, 8 or 16 and from the shared divider in other bases (8 quotient bits a
// cycle), and the top digit is fetched before the first character. Characters leave at
// one per cycle while the output is not stalled. A bad radix gives a single result.
// A new request is not taken until the last character of the one before is in the output
// register.
// Reset clears the sequencer and the output valid.
module integer_to_ascii_radix import itoa_pkg::*; #(
  parameter int DIGIT_DEPTH = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [DATA_W-1:0]  value,
  input  logic [RADIX_W-1:0]        radix,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [CHAR_W-1:0]         character,
  output logic                      last_char,
  output logic                      bad_radix
);

  localparam int ADDR_W = $clog2(DIGIT_DEPTH);
  localparam int CNT_W  = $clog2(DIGIT_DEPTH + 1);

  itoa_state_t state, state_next;

  logic [DATA_W-1:0]      quotient;
  logic [RADIX_W-1:0]     rem;
  logic [CHUNK_CNT_W-1:0] chunk;
  logic [RADIX_W-1:0]     radix_reg;
  logic                   pow2;
  logic [SHIFT_W-1:0]     shift_amt;
  logic                   negative;
  logic [CNT_W-1:0]       count;
  logic [ADDR_W-1:0]      idx;

  logic                   accept;
  logic                   radix_bad;
  logic                   radix_pow2;
  logic [SHIFT_W-1:0]     radix_shift;
  logic                   in_negative;

  logic [RADIX_W-1:0]     rem_step;
  logic [CHUNK_BITS-1:0]  quot_bits;
  logic [DATA_W-1:0]      quot_step;
  logic [DIGIT_W-1:0]     digit_mask;
  logic [DIGIT_W-1:0]     digit_p2;
  logic [DATA_W-1:0]      quot_p2;

  logic                   digit_write;
  logic [DIGIT_W-1:0]     digit_value;
  logic [DATA_W-1:0]      quot_new;
  logic [CNT_W-1:0]       count_inc;
  logic                   divide_done;

  logic                   slot_free;
  logic                   load_out;
  logic [CHAR_W-1:0]      load_char;
  logic                   load_last;
  logic                   load_bad;
  logic [ADDR_W-1:0]      rd_addr;
  logic [DIGIT_W-1:0]     rd_data;

  // Input handshake and request decode
  assign in_stall    = (state != ST_IDLE);
  assign accept      = in_valid && !in_stall;
  assign radix_bad   = (radix < RADIX_MIN) || (radix > RADIX_MAX);
  assign in_negative = (radix == RADIX_TEN) && value[DATA_W-1];

  // Map power-of-two bases to a shift amount
  always_comb begin
    radix_pow2  = 1'b1;
    radix_shift = '0;
    unique case (radix)
      RADIX_TWO:     radix_shift = 3'd1;
      RADIX_FOUR:    radix_shift = 3'd2;
      RADIX_EIGHT:   radix_shift = 3'd3;
      RADIX_SIXTEEN: radix_shift = 3'd4;
      default:       radix_pow2  = 1'b0;
    endcase
  end

  // Shared divider: eight restoring steps on the top byte of the quotient
  always_comb begin
    logic [RADIX_W-1:0] r;
    logic [RADIX_W-1:0] t;
    r         = rem;
    quot_bits = '0;
    for (int i = 0; i < CHUNK_BITS; i++) begin
      t = {r[DIGIT_W-1:0], quotient[DATA_W-1-i]};
      if (t >= radix_reg) begin
        t = t - radix_reg;
        quot_bits[CHUNK_BITS-1-i] = 1'b1;
      end
      r = t;
    end
    rem_step = r;
  end
  assign quot_step = {quotient[DATA_W-CHUNK_BITS-1:0], quot_bits};

  // Shift path for power-of-two bases
  assign digit_mask = radix_reg[DIGIT_W-1:0] - 1'b1;
  assign digit_p2   = quotient[DIGIT_W-1:0] & digit_mask;
  assign quot_p2    = quotient >> shift_amt;

  // Digit completion
  assign digit_write = (state == ST_DIVIDE) &&
                       (pow2 || (chunk == CHUNK_CNT_W'(CHUNKS - 1)));
  assign digit_value = pow2 ? digit_p2 : rem_step[DIGIT_W-1:0];
  assign quot_new    = pow2 ? quot_p2 : quot_step;
  assign count_inc   = count + 1'b1;
  assign divide_done = digit_write &&
                       ((quot_new == '0) || (count_inc == CNT_W'(DIGIT_DEPTH)));

  // Output slot is free when empty or being taken this cycle
  assign slot_free = !out_valid || !out_stall;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = radix_bad ? ST_ERROR : ST_DIVIDE;
        end
      end
      ST_ERROR: begin
        if (slot_free) state_next = ST_IDLE;
      end
      ST_DIVIDE: begin
        if (divide_done) state_next = ST_FETCH;
      end
      ST_FETCH: begin
        state_next = negative ? ST_SIGN : ST_EMIT;
      end
      ST_SIGN: begin
        if (slot_free) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free && (idx == '0)) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Output register loads and digit read address
  always_comb begin
    load_out  = 1'b0;
    load_char = CHAR_ERROR;
    load_last = 1'b0;
    load_bad  = 1'b0;
    rd_addr   = idx;
    unique case (state)
      ST_ERROR: begin
        load_out  = slot_free;
        load_last = 1'b1;
        load_bad  = 1'b1;
      end
      ST_SIGN: begin
        load_out  = slot_free;
        load_char = CHAR_MINUS;
      end
      ST_EMIT: begin
        load_out  = slot_free;
        load_char = GLYPHS[rd_data];
        load_last = (idx == '0);
        if (slot_free && (idx != '0)) rd_addr = idx - 1'b1;
      end
      default: begin
        load_out = 1'b0;
      end
    endcase
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        count <= '0;
      end else if (digit_write) begin
        count <= count_inc;
      end
    end
  end

  // Load a new request, advance the divider, step down through the digits
  always_ff @(posedge clk) begin
    if (accept) begin
      radix_reg <= radix;
      pow2      <= radix_pow2;
      shift_amt <= radix_shift;
      negative  <= in_negative;
      quotient  <= in_negative ? (~value + 1'b1) : value;
      rem       <= '0;
      chunk     <= '0;
    end else if (state == ST_DIVIDE) begin
      quotient <= quot_new;
      if (digit_write) begin
        rem   <= '0;
        chunk <= '0;
      end else begin
        rem   <= rem_step;
        chunk <= chunk + 1'b1;
      end
    end
    if (divide_done) begin
      idx <= count[ADDR_W-1:0];
    end else if ((state == ST_EMIT) && slot_free && (idx != '0)) begin
      idx <= idx - 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      character <= load_char;
      last_char <= load_last;
      bad_radix <= load_bad;
    end
  end

  // Digit store
  itoa_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (DIGIT_DEPTH)
  ) u_digits (
    .clk     (clk),
    .wr_en   (digit_write),
    .wr_addr (count[ADDR_W-1:0]),
    .wr_data (digit_value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Divider remainder stays below the base
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVIDE) && !pow2 |-> (rem < radix_reg))
    else $error("divider remainder not below radix");

  // Digit count never passes the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DIGIT_DEPTH))
    else $error("digit count beyond store depth");

  // A bad radix request goes straight to the error result
  a_bad_path: assert property (@(posedge clk) disable iff (rst)
    accept && radix_bad |=> (state == ST_ERROR))
    else $error("bad radix request did not take error path");

  // Error results are single, zero and flagged last
  a_bad_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_radix |-> last_char && (character == CHAR_ERROR))
    else $error("malformed error result");

  // A minus sign only comes from a signed base and is never the last character
  a_minus_base: assert property (@(posedge clk) disable iff (rst)
    out_valid && !bad_radix && (character == CHAR_MINUS) |->
      (radix_reg == RADIX_TEN) && !last_char)
    else $error("minus sign outside base ten conversion");

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the integer to ASCII radix converter.
module testbench import itoa_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400_000;
  localparam int DIGITS_MAX   = 32;
  localparam int DRAIN_CYCLES = 64;
  localparam int RANDOM_ITEMS = 185;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last_char;
    logic              bad_radix;
  } char_result_t;

  // Expected character stream and its checker
  class char_scoreboard;
    char_result_t pending_chars[$];
    int           mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Map a digit value to its uppercase glyph ('0' is 8'h30, 'A' is 8'h37 + 10)
    function logic [CHAR_W-1:0] glyph_of(logic [DIGIT_W-1:0] digit);
      return (digit < 4'd10) ? (8'h30 + 8'(digit)) : (8'h37 + 8'(digit));
    endfunction

    // Spell out an accepted request and queue every character it yields
    function void note_request(logic signed [DATA_W-1:0] number, logic [RADIX_W-1:0] base);
      logic [DIGIT_W-1:0] digits [DIGITS_MAX];
      logic [DATA_W-1:0]  quotient;
      logic [DATA_W-1:0]  divisor;
      bit                 negative;
      int                 count;
      if (base < RADIX_MIN || base > RADIX_MAX) begin
        pending_chars.push_back('{CHAR_ERROR, 1'b1, 1'b1});
        return;
      end
      divisor  = 32'(base);
      negative = (base == RADIX_TEN) && number[DATA_W-1];
      // magnitude wraps modulo 2^32, so the most negative value stays intact
      quotient = negative ? (32'd0 - number) : number;
      count    = 0;
      do begin
        digits[count] = DIGIT_W'(quotient % divisor);
        count++;
        quotient = quotient / divisor;
      end while (quotient != 0 && count < DIGITS_MAX);
      if (negative)
        pending_chars.push_back('{CHAR_MINUS, 1'b0, 1'b0});
      for (int i = count - 1; i >= 0; i--)
        pending_chars.push_back('{glyph_of(digits[i]), i == 0, 1'b0});
    endfunction

    // Compare one delivered character with the oldest expectation
    function void check_char(logic [CHAR_W-1:0] character, logic last_char, logic bad_radix);
      char_result_t expected;
      if (pending_chars.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: unexpected character %h last=%b bad=%b",
                   $realtime, character, last_char, bad_radix);
        mismatches++;
        return;
      end
      expected = pending_chars.pop_front();
      if (character !== expected.character || last_char !== expected.last_char ||
          bad_radix !== expected.bad_radix) begin
        if (mismatches < 10)
          $display("%0t: expected char %h last=%b bad=%b, got char %h last=%b bad=%b",
                   $realtime, expected.character, expected.last_char, expected.bad_radix,
                   character, last_char, bad_radix);
        mismatches++;
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [DATA_W-1:0] value = '0;
  logic [RADIX_W-1:0]       radix = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [CHAR_W-1:0]        character;
  logic                     last_char;
  logic                     bad_radix;

  char_scoreboard sb = new();
  bit             idle_on = 1'b0;
  int             cycle_count = 0;
  int             out_stall_left = 0;

  integer_to_ascii_radix u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .radix     (radix),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .character (character),
    .last_char (last_char),
    .bad_radix (bad_radix)
  );

  always #4 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("integer_to_ascii_radix verification failed");
      $finish;
    end
  end

  // Hold off the output in short random bursts
  always @(negedge clk) begin
    if (out_stall_left > 0) begin
      out_stall_left--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_stall_left = $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Check every character taken from the output
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_char(character, last_char, bad_radix);
  end

  // Offer one request, wait for it to be taken, then maybe drop valid for a while
  task automatic send_request(logic signed [DATA_W-1:0] number, logic [RADIX_W-1:0] base);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    value    <= number;
    radix    <= base;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_request(number, base);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Pick a value that mixes full-width patterns with short and extreme ones
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom;
      5, 6:          return $urandom_range(0, 1000);
      7:             return -$signed(32'($urandom_range(1, 1000)));
      8: begin
        case ($urandom_range(0, 3))
          0:       return 32'h0000_0000;
          1:       return 32'hFFFF_FFFF;
          2:       return 32'h8000_0000;
          default: return 32'h7FFF_FFFF;
        endcase
      end
      default:       return 32'h1 << $urandom_range(0, 31);
    endcase
  endfunction

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: bad bases, zero, extremes, sign handling and every valid base
    idle_on = 1'b1;
    send_request(32'sd0, 5'd0);
    send_request(32'sd123, 5'd1);
    send_request(-32'sd5, 5'd17);
    send_request(32'h7FFF_FFFF, 5'd31);
    send_request(32'sd0, RADIX_TEN);
    send_request(32'sd0, RADIX_TWO);
    send_request(32'h7FFF_FFFF, RADIX_TEN);
    send_request(32'h8000_0000, RADIX_TEN);
    send_request(-32'sd1, RADIX_TEN);
    send_request(-32'sd1, RADIX_TWO);
    send_request(-32'sd1, RADIX_SIXTEEN);
    send_request(32'h8000_0000, RADIX_SIXTEEN);
    send_request(-32'sd1, RADIX_EIGHT);
    send_request(-32'sd1, RADIX_FOUR);
    send_request(32'sd12345, 5'd3);
    for (int b = 5; b <= 15; b++)
      if (b != RADIX_EIGHT && b != RADIX_TEN)
        send_request(-32'sd1, 5'(b));
    send_request(32'sd255, RADIX_SIXTEEN);

    // Random: quiet stretches in the middle and at the tail
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idle_on = !((i >= 70 && i < 95) || i >= RANDOM_ITEMS - 40);
      send_request(pick_value(),
                   ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                               : 5'($urandom_range(2, 16)));
    end

    @(negedge clk);
    in_valid <= 1'b0;

    // Drain the output, then let the block settle
    while (sb.pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending_chars.size() == 0) begin
      $display("integer_to_ascii_radix verification clean");
    end else begin
      $display("integer_to_ascii_radix verification failed");
    end
    $finish;
  end

endmodule
